@@ design/csl_pkg.sv @@
// Shared types, constants and arithmetic steps for the cylinder/sphere local frame block.
`timescale 1ns / 1ps
`default_nettype none
package csl_pkg;

   localparam int OUT_FRAC_BITS = 30;
   localparam int QW            = OUT_FRAC_BITS + 1;   // quotient magnitude width
   localparam int RW            = 32;                  // square root width
   localparam int SQRT_STAGES   = RW;
   localparam int DIV_STAGES    = QW;
   localparam int SQRT_LANES    = 3;
   localparam int DIV_LANES     = 6;

   localparam logic [QW-1:0] ONE_MAG = {1'b1, {OUT_FRAC_BITS{1'b0}}};

   // square root lanes
   localparam int SQ_R2  = 0;
   localparam int SQ_LEN = 1;
   localparam int SQ_RN  = 2;

   // divider lanes
   localparam int DV_C  = 0;
   localparam int DV_S  = 1;
   localparam int DV_CP = 2;
   localparam int DV_SP = 3;
   localparam int DV_RX = 4;
   localparam int DV_RY = 5;

   typedef struct packed {
      logic valid;
      logic cyl;
      logic xy_zero;
      logic deg;
      logic neg_x;
      logic neg_y;
      logic neg_dz;
   } side_type;

   typedef struct packed {
      logic [30:0] v2x;
      logic [30:0] v2y;
      logic [30:0] v3x;
      logic [30:0] v3y;
      logic [30:0] v3z;
   } vals_type;

   typedef struct packed {
      logic [2*RW-1:0] rem;
      logic [RW-1:0]   root;
   } sqrt_lane_type;

   typedef struct packed {
      logic [RW:0]   rem;
      logic [QW-1:0] quo;
      logic [QW-1:0] low;
      logic [RW-1:0] dvs;
   } div_lane_type;

   function automatic logic [5:0] msb_index(input logic [32:0] v);
      logic [5:0] idx;
      idx = '0;
      for (int i = 0; i < 33; i++) begin
         if (v[i]) idx = 6'(i);
      end
      return idx;
   endfunction

   // bring the top set bit to position 30
   function automatic logic [30:0] norm_shift(input logic [32:0] v, input logic [5:0] p);
      logic [30:0] r;
      if (p > 6'd30) begin
         r = 31'(v >> (p - 6'd30));
      end else begin
         r = 31'({31'b0, v} << (6'd30 - p));
      end
      return r;
   endfunction

   // one result bit of the square root; rem holds radicand minus root squared
   function automatic sqrt_lane_type sqrt_step(input sqrt_lane_type a, input int bit_pos);
      sqrt_lane_type r;
      logic [2*RW-1:0] trial;
      r = a;
      trial = ({{RW{1'b0}}, a.root} << (bit_pos + 1)) | ((2*RW)'(1) << (2 * bit_pos));
      if (a.rem >= trial) begin
         r.rem  = a.rem - trial;
         r.root = a.root | (RW'(1) << bit_pos);
      end
      return r;
   endfunction

   // dividend is num * 2^F + dvs/2, rounded quotient comes out after QW steps
   function automatic div_lane_type div_init(input logic [RW-1:0] num,
                                             input logic [RW-1:0] dvs);
      div_lane_type r;
      logic [2*RW-1:0] n;
      n = ({{RW{1'b0}}, num} << OUT_FRAC_BITS) + {{(RW+1){1'b0}}, dvs[RW-1:1]};
      r.rem = (RW+1)'(n >> QW);
      r.low = n[QW-1:0];
      r.quo = '0;
      r.dvs = dvs;
      return r;
   endfunction

   function automatic div_lane_type div_step(input div_lane_type a);
      div_lane_type r;
      logic [RW:0] t;
      r = a;
      t = {a.rem[RW-1:0], a.low[QW-1]};
      r.low = a.low << 1;
      if (t >= {1'b0, a.dvs}) begin
         r.rem = t - {1'b0, a.dvs};
         r.quo = {a.quo[QW-2:0], 1'b1};
      end else begin
         r.rem = t;
         r.quo = {a.quo[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [31:0] signed_out(input logic [QW-1:0] m, input logic neg);
      logic [31:0] e;
      e = 32'(m);
      return neg ? (32'd0 - e) : e;
   endfunction

endpackage
`default_nettype wire

@@ design/cylinder_sphere_local_frame.sv @@
// Top level: pipelined global-to-local rotation for the cylinder and spherical cap frames.
// A word accepted on start passes 5 front stages, 32 square root stages, 31 divider stages
//   and 3 output stages before it appears on rsp_valid.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Reset (synchronous, active high) clears all valid bits and sets cap_height to 0.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module cylinder_sphere_local_frame (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [31:0] req_x_coord,
   input  wire logic [31:0] req_y_coord,
   input  wire logic [31:0] req_z_coord,
   input  wire logic        req_on_cylinder_patch,
   output      logic        rsp_valid,
   output      logic [31:0] rsp_m11,
   output      logic [31:0] rsp_m12,
   output      logic [31:0] rsp_m13,
   output      logic [31:0] rsp_m21,
   output      logic [31:0] rsp_m22,
   output      logic [31:0] rsp_m23,
   output      logic [31:0] rsp_m31,
   output      logic [31:0] rsp_m32,
   output      logic [31:0] rsp_m33,
   output      logic        rsp_degenerate,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [31:0] csr_wdata
);

   localparam int SQ = csl_pkg::SQRT_STAGES;
   localparam int DV = csl_pkg::DIV_STAGES;
   localparam int QW = csl_pkg::QW;
   localparam int F  = csl_pkg::OUT_FRAC_BITS;

   logic [31:0] cap_ff;

   // stage 0: magnitudes and flags
   csl_pkg::side_type s0_side_ff, s0_side_in;
   logic [31:0] s0_ax_ff, s0_ay_ff, s0_ax_in, s0_ay_in;
   logic [32:0] s0_adz_ff, s0_adz_in;
   // stage 1: shift positions
   csl_pkg::side_type s1_side_ff;
   logic [31:0] s1_ax_ff, s1_ay_ff;
   logic [32:0] s1_adz_ff;
   logic [5:0]  s1_p2_ff, s1_p3_ff, s1_p2_in, s1_p3_in;
   // stage 2: normalized values
   csl_pkg::side_type s2_side_ff;
   csl_pkg::vals_type s2_vals_ff, s2_vals_in;
   // stage 3: squares
   csl_pkg::side_type s3_side_ff;
   csl_pkg::vals_type s3_vals_ff;
   logic [61:0] s3_q2x_ff, s3_q2y_ff, s3_q3x_ff, s3_q3y_ff, s3_q3z_ff;
   // stage 4: sums
   csl_pkg::side_type s4_side_ff;
   csl_pkg::vals_type s4_vals_ff;
   logic [63:0] s4_sum2_ff, s4_sum3_ff, s4_sumxy_ff;

   csl_pkg::sqrt_lane_type sq_ff [SQ][csl_pkg::SQRT_LANES];
   csl_pkg::sqrt_lane_type sq_in [SQ][csl_pkg::SQRT_LANES];
   csl_pkg::side_type      sq_side_ff [SQ];
   csl_pkg::vals_type      sq_vals_ff [SQ];

   csl_pkg::div_lane_type dv_ff [DV][csl_pkg::DIV_LANES];
   csl_pkg::div_lane_type dv_in [DV][csl_pkg::DIV_LANES];
   csl_pkg::side_type     dv_side_ff [DV];

   csl_pkg::side_type e1_side_ff, e2_side_ff;
   logic [QW-1:0] e1_mag_ff [csl_pkg::DIV_LANES];
   logic [QW-1:0] e1_mag_in [csl_pkg::DIV_LANES];
   logic [QW-1:0] e2_mag_ff [csl_pkg::DIV_LANES];
   logic [2*QW-1:0] e2_pc_ff, e2_ps_ff;

   logic        rsp_valid_ff;
   logic [31:0] m_ff [9];
   logic [31:0] m_in [9];
   logic        deg_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_wdata;
      end
   end

   always_comb begin
      logic [32:0] dz;
      logic        xy_zero;
      dz       = {req_z_coord[31], req_z_coord} - {cap_ff[31], cap_ff};
      xy_zero  = (req_x_coord == '0) && (req_y_coord == '0);
      s0_ax_in  = req_x_coord[31] ? (32'd0 - req_x_coord) : req_x_coord;
      s0_ay_in  = req_y_coord[31] ? (32'd0 - req_y_coord) : req_y_coord;
      s0_adz_in = dz[32] ? (33'd0 - dz) : dz;
      s0_side_in.valid   = start && !busy;
      s0_side_in.cyl     = req_on_cylinder_patch;
      s0_side_in.xy_zero = xy_zero;
      s0_side_in.deg     = req_on_cylinder_patch ? xy_zero : (xy_zero && (dz == '0));
      s0_side_in.neg_x   = req_x_coord[31];
      s0_side_in.neg_y   = req_y_coord[31];
      s0_side_in.neg_dz  = dz[32];
   end

   always_comb begin
      logic [31:0] m2;
      logic [32:0] m3;
      m2 = (s0_ax_ff > s0_ay_ff) ? s0_ax_ff : s0_ay_ff;
      m3 = ({1'b0, m2} > s0_adz_ff) ? {1'b0, m2} : s0_adz_ff;
      s1_p2_in = csl_pkg::msb_index({1'b0, m2});
      s1_p3_in = csl_pkg::msb_index(m3);
   end

   always_comb begin
      s2_vals_in.v2x = csl_pkg::norm_shift({1'b0, s1_ax_ff}, s1_p2_ff);
      s2_vals_in.v2y = csl_pkg::norm_shift({1'b0, s1_ay_ff}, s1_p2_ff);
      s2_vals_in.v3x = csl_pkg::norm_shift({1'b0, s1_ax_ff}, s1_p3_ff);
      s2_vals_in.v3y = csl_pkg::norm_shift({1'b0, s1_ay_ff}, s1_p3_ff);
      s2_vals_in.v3z = csl_pkg::norm_shift(s1_adz_ff, s1_p3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_side_ff <= '0;
         s1_side_ff <= '0;
         s2_side_ff <= '0;
         s3_side_ff <= '0;
         s4_side_ff <= '0;
      end else begin
         s0_side_ff <= s0_side_in;
         s1_side_ff <= s0_side_ff;
         s2_side_ff <= s1_side_ff;
         s3_side_ff <= s2_side_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_ax_ff    <= s0_ax_in;
      s0_ay_ff    <= s0_ay_in;
      s0_adz_ff   <= s0_adz_in;
      s1_ax_ff    <= s0_ax_ff;
      s1_ay_ff    <= s0_ay_ff;
      s1_adz_ff   <= s0_adz_ff;
      s1_p2_ff    <= s1_p2_in;
      s1_p3_ff    <= s1_p3_in;
      s2_vals_ff  <= s2_vals_in;
      s3_vals_ff  <= s2_vals_ff;
      s3_q2x_ff   <= s2_vals_ff.v2x * s2_vals_ff.v2x;
      s3_q2y_ff   <= s2_vals_ff.v2y * s2_vals_ff.v2y;
      s3_q3x_ff   <= s2_vals_ff.v3x * s2_vals_ff.v3x;
      s3_q3y_ff   <= s2_vals_ff.v3y * s2_vals_ff.v3y;
      s3_q3z_ff   <= s2_vals_ff.v3z * s2_vals_ff.v3z;
      s4_vals_ff  <= s3_vals_ff;
      s4_sum2_ff  <= 64'(s3_q2x_ff) + 64'(s3_q2y_ff);
      s4_sumxy_ff <= 64'(s3_q3x_ff) + 64'(s3_q3y_ff);
      s4_sum3_ff  <= 64'(s3_q3x_ff) + 64'(s3_q3y_ff) + 64'(s3_q3z_ff);
   end

   // square root pipeline: one root bit per stage, three lanes
   always_comb begin
      csl_pkg::sqrt_lane_type init [csl_pkg::SQRT_LANES];
      init[csl_pkg::SQ_R2].rem  = s4_sum2_ff;
      init[csl_pkg::SQ_LEN].rem = s4_sum3_ff;
      init[csl_pkg::SQ_RN].rem  = s4_sumxy_ff;
      for (int l = 0; l < csl_pkg::SQRT_LANES; l++) begin
         init[l].root = '0;
      end
      for (int k = 0; k < SQ; k++) begin
         for (int l = 0; l < csl_pkg::SQRT_LANES; l++) begin
            sq_in[k][l] = csl_pkg::sqrt_step((k == 0) ? init[l] : sq_ff[k-1][l], SQ - 1 - k);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQ; k++) begin
         for (int l = 0; l < csl_pkg::SQRT_LANES; l++) begin
            sq_ff[k][l] <= sq_in[k][l];
         end
         sq_vals_ff[k] <= (k == 0) ? s4_vals_ff : sq_vals_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQ; k++) begin
         if (reset) begin
            sq_side_ff[k] <= '0;
         end else begin
            sq_side_ff[k] <= (k == 0) ? s4_side_ff : sq_side_ff[k-1];
         end
      end
   end

   // divider pipeline: one quotient bit per stage, six lanes
   always_comb begin
      csl_pkg::div_lane_type init [csl_pkg::DIV_LANES];
      csl_pkg::vals_type     v;
      logic [31:0]           r2, len, rn;
      v   = sq_vals_ff[SQ-1];
      r2  = sq_ff[SQ-1][csl_pkg::SQ_R2].root;
      len = sq_ff[SQ-1][csl_pkg::SQ_LEN].root;
      rn  = sq_ff[SQ-1][csl_pkg::SQ_RN].root;
      init[csl_pkg::DV_C]  = csl_pkg::div_init({1'b0, v.v2x}, r2);
      init[csl_pkg::DV_S]  = csl_pkg::div_init({1'b0, v.v2y}, r2);
      init[csl_pkg::DV_CP] = csl_pkg::div_init({1'b0, v.v3z}, len);
      init[csl_pkg::DV_SP] = csl_pkg::div_init(rn, len);
      init[csl_pkg::DV_RX] = csl_pkg::div_init({1'b0, v.v3x}, len);
      init[csl_pkg::DV_RY] = csl_pkg::div_init({1'b0, v.v3y}, len);
      for (int k = 0; k < DV; k++) begin
         for (int l = 0; l < csl_pkg::DIV_LANES; l++) begin
            dv_in[k][l] = csl_pkg::div_step((k == 0) ? init[l] : dv_ff[k-1][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DV; k++) begin
         for (int l = 0; l < csl_pkg::DIV_LANES; l++) begin
            dv_ff[k][l] <= dv_in[k][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DV; k++) begin
         if (reset) begin
            dv_side_ff[k] <= '0;
         end else begin
            dv_side_ff[k] <= (k == 0) ? sq_side_ff[SQ-1] : dv_side_ff[k-1];
         end
      end
   end

   // clamp to one; a point on the axis takes theta 0
   always_comb begin
      for (int l = 0; l < csl_pkg::DIV_LANES; l++) begin
         e1_mag_in[l] = (dv_ff[DV-1][l].quo > csl_pkg::ONE_MAG) ? csl_pkg::ONE_MAG
                                                                : dv_ff[DV-1][l].quo;
      end
      if (dv_side_ff[DV-1].xy_zero) begin
         e1_mag_in[csl_pkg::DV_C] = csl_pkg::ONE_MAG;
         e1_mag_in[csl_pkg::DV_S] = '0;
      end
   end

   always_comb begin
      logic [2*QW-1:0] half;
      logic [QW-1:0]   rc, rs;
      csl_pkg::side_type sd;
      sd   = e2_side_ff;
      half = (2*QW)'(1) << (F - 1);
      rc   = QW'((e2_pc_ff + half) >> F);
      rs   = QW'((e2_ps_ff + half) >> F);
      for (int i = 0; i < 9; i++) begin
         m_in[i] = '0;
      end
      if (!sd.deg) begin
         m_in[3] = csl_pkg::signed_out(e2_mag_ff[csl_pkg::DV_S], !sd.neg_y);
         m_in[4] = csl_pkg::signed_out(e2_mag_ff[csl_pkg::DV_C], sd.neg_x);
         if (sd.cyl) begin
            m_in[2] = csl_pkg::signed_out(csl_pkg::ONE_MAG, 1'b1);
            m_in[6] = csl_pkg::signed_out(e2_mag_ff[csl_pkg::DV_C], sd.neg_x);
            m_in[7] = csl_pkg::signed_out(e2_mag_ff[csl_pkg::DV_S], sd.neg_y);
         end else begin
            m_in[0] = csl_pkg::signed_out(rc, sd.neg_x ^ sd.neg_dz);
            m_in[1] = csl_pkg::signed_out(rs, sd.neg_y ^ sd.neg_dz);
            m_in[2] = csl_pkg::signed_out(e2_mag_ff[csl_pkg::DV_SP], 1'b1);
            m_in[6] = csl_pkg::signed_out(e2_mag_ff[csl_pkg::DV_RX], sd.neg_x);
            m_in[7] = csl_pkg::signed_out(e2_mag_ff[csl_pkg::DV_RY], sd.neg_y);
            m_in[8] = csl_pkg::signed_out(e2_mag_ff[csl_pkg::DV_CP], sd.neg_dz);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < csl_pkg::DIV_LANES; l++) begin
         e1_mag_ff[l] <= e1_mag_in[l];
         e2_mag_ff[l] <= e1_mag_ff[l];
      end
      e2_pc_ff <= e1_mag_ff[csl_pkg::DV_C] * e1_mag_ff[csl_pkg::DV_CP];
      e2_ps_ff <= e1_mag_ff[csl_pkg::DV_S] * e1_mag_ff[csl_pkg::DV_CP];
      for (int i = 0; i < 9; i++) begin
         m_ff[i] <= m_in[i];
      end
      deg_ff <= e2_side_ff.deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_side_ff   <= '0;
         e2_side_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e1_side_ff   <= dv_side_ff[DV-1];
         e2_side_ff   <= e1_side_ff;
         rsp_valid_ff <= e2_side_ff.valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_m11        = m_ff[0];
   assign rsp_m12        = m_ff[1];
   assign rsp_m13        = m_ff[2];
   assign rsp_m21        = m_ff[3];
   assign rsp_m22        = m_ff[4];
   assign rsp_m23        = m_ff[5];
   assign rsp_m31        = m_ff[6];
   assign rsp_m32        = m_ff[7];
   assign rsp_m33        = m_ff[8];
   assign rsp_degenerate = deg_ff;

endmodule
`default_nettype wire

@@ design/csl_checker.sv @@
// Port-level checks for the local frame block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module csl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_m11,
   input wire logic [31:0] rsp_m12,
   input wire logic [31:0] rsp_m13,
   input wire logic [31:0] rsp_m21,
   input wire logic [31:0] rsp_m22,
   input wire logic [31:0] rsp_m23,
   input wire logic [31:0] rsp_m31,
   input wire logic [31:0] rsp_m32,
   input wire logic [31:0] rsp_m33,
   input wire logic        rsp_degenerate
);

   localparam int LATENCY = 71;

   // every accepted word comes out after the fixed latency
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word did not appear after pipeline latency");

   a_latency_back : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result word without a matching accepted word");

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_m11 == '0) && (rsp_m12 == '0) && (rsp_m13 == '0) &&
         (rsp_m21 == '0) && (rsp_m22 == '0) && (rsp_m23 == '0) &&
         (rsp_m31 == '0) && (rsp_m32 == '0) && (rsp_m33 == '0))
      else $error("degenerate word with a nonzero entry");

   a_theta_row : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m23 == '0))
      else $error("theta row has a z component");

endmodule

bind cylinder_sphere_local_frame csl_checker u_csl_checker (.*);
`default_nettype wire

@@ bench/cylinder_sphere_local_frame_checker.sv @@
// Checker: watches the point and matrix channels, predicts each rotation and compares.
`timescale 1ns / 1ps
`default_nettype none
module cylinder_sphere_local_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [31:0] req_x_coord,
   input  wire logic [31:0] req_y_coord,
   input  wire logic [31:0] req_z_coord,
   input  wire logic        req_on_cylinder_patch,
   input  wire logic        rsp_valid,
   input  wire logic [31:0] rsp_m11,
   input  wire logic [31:0] rsp_m12,
   input  wire logic [31:0] rsp_m13,
   input  wire logic [31:0] rsp_m21,
   input  wire logic [31:0] rsp_m22,
   input  wire logic [31:0] rsp_m23,
   input  wire logic [31:0] rsp_m31,
   input  wire logic [31:0] rsp_m32,
   input  wire logic [31:0] rsp_m33,
   input  wire logic        rsp_degenerate,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   typedef struct {
      logic [31:0] m [9];
      logic        degenerate;
   } frame_type;

   localparam longint ONE = 64'sd1 << csl_pkg::OUT_FRAC_BITS;

   frame_type   frame_queue [$];
   logic signed [31:0] cap_height_q;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // scale all magnitudes together until the largest sits in [2^30, 2^31)
   function automatic void scale_group(ref longint unsigned v [3], input int n);
      longint unsigned top;
      top = 0;
      for (int i = 0; i < n; i++) if (v[i] > top) top = v[i];
      if (top == 0) return;
      while (top >= (64'd1 << 31)) begin
         top >>= 1;
         for (int i = 0; i < n; i++) v[i] >>= 1;
      end
      while (top < (64'd1 << 30)) begin
         top <<= 1;
         for (int i = 0; i < n; i++) v[i] <<= 1;
      end
   endfunction

   function automatic longint unit_ratio(input longint unsigned a, input bit neg,
                                         input longint unsigned n);
      longint unsigned q;
      if (n == 0) return 0;
      q = ((a << csl_pkg::OUT_FRAC_BITS) + (n >> 1)) / n;
      if (q > ONE) q = ONE;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint frac_mul(input longint a, input longint b);
      longint unsigned p;
      p = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
      p = (p + (64'd1 << (csl_pkg::OUT_FRAC_BITS - 1))) >> csl_pkg::OUT_FRAC_BITS;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic frame_type predict_frame(input logic signed [31:0] x,
         input logic signed [31:0] y, input logic signed [31:0] z, input logic cyl);
      frame_type f;
      longint dz, m [9], c, s, cp, sp;
      longint unsigned ax, ay, adz, len, rn;
      longint unsigned v [3];
      dz = longint'(z) - longint'(cap_height_q);
      ax = x < 0 ? -longint'(x) : longint'(x);
      ay = y < 0 ? -longint'(y) : longint'(y);
      adz = dz < 0 ? -dz : dz;
      for (int i = 0; i < 9; i++) m[i] = 0;
      c = ONE;
      s = 0;
      f.degenerate = 1'b0;
      if ((ax | ay) != 0) begin
         v[0] = ax; v[1] = ay; v[2] = 0;
         scale_group(v, 2);
         rn = int_sqrt(v[0] * v[0] + v[1] * v[1]);
         c = unit_ratio(v[0], x < 0, rn);
         s = unit_ratio(v[1], y < 0, rn);
      end
      if (cyl) begin
         if ((ax | ay) == 0) f.degenerate = 1'b1;
         else begin
            m[2] = -ONE; m[3] = -s; m[4] = c; m[6] = c; m[7] = s;
         end
      end else if ((ax | ay | adz) == 0) begin
         f.degenerate = 1'b1;
      end else begin
         v[0] = ax; v[1] = ay; v[2] = adz;
         scale_group(v, 3);
         len = int_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
         rn = int_sqrt(v[0] * v[0] + v[1] * v[1]);
         cp = unit_ratio(v[2], dz < 0, len);
         sp = unit_ratio(rn, 1'b0, len);
         m[0] = frac_mul(c, cp);
         m[1] = frac_mul(s, cp);
         m[2] = -sp; m[3] = -s; m[4] = c;
         m[6] = unit_ratio(v[0], x < 0, len);
         m[7] = unit_ratio(v[1], y < 0, len);
         m[8] = cp;
      end
      for (int i = 0; i < 9; i++) f.m[i] = m[i][31:0];
      return f;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      frame_type want;
      logic [31:0] got [9];
      got = '{rsp_m11, rsp_m12, rsp_m13, rsp_m21, rsp_m22, rsp_m23,
              rsp_m31, rsp_m32, rsp_m33};
      if (reset) begin
         cap_height_q <= '0;
      end else begin
         // predict with the setting in force at this edge
         if (start && !busy)
            frame_queue.push_back(predict_frame(req_x_coord, req_y_coord,
                                                req_z_coord, req_on_cylinder_patch));
         if (csr_valid && csr_ready) cap_height_q <= csr_wdata;
         if (rsp_valid) begin
            if (frame_queue.size() == 0) begin
               report_mismatch("unexpected word", got[0], '0);
            end else begin
               want = frame_queue.pop_front();
               for (int i = 0; i < 9; i++)
                  if (got[i] !== want.m[i])
                     report_mismatch($sformatf("m%0d%0d", i / 3 + 1, i % 3 + 1),
                                     got[i], want.m[i]);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", 32'(rsp_degenerate), 32'(want.degenerate));
            end
         end
      end
      pending_count <= frame_queue.size();
   end
endmodule
`default_nettype wire

@@ bench/cylinder_sphere_local_frame_tb.sv @@
// Testbench top: drives points and cap heights into the local frame block, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module cylinder_sphere_local_frame_tb;
   localparam int LATENCY = 71;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock, reset, start, busy;
   logic [31:0] req_x_coord, req_y_coord, req_z_coord;
   logic        req_on_cylinder_patch;
   logic        rsp_valid, rsp_degenerate;
   logic [31:0] rsp_m11, rsp_m12, rsp_m13, rsp_m21, rsp_m22, rsp_m23;
   logic [31:0] rsp_m31, rsp_m32, rsp_m33;
   logic        csr_valid, csr_ready;
   logic [31:0] csr_wdata;
   int          fail_count, pending_count;
   longint      cycle_count;
   int          idle_pct;

   cylinder_sphere_local_frame uut (.*);
   cylinder_sphere_local_frame_checker checker_i (.*);

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000)) - 1000);
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         3: return 32'($signed($urandom_range(0, 20)) - 10) << $urandom_range(0, 31);
         4: return 32'h0;
         default: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19) << 8;
      endcase
   endfunction

   task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic cyl);
      while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      req_on_cylinder_patch <= cyl;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // drain the pipeline, then write the cap height while idle
   task automatic set_cap_height(input logic [31:0] h);
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] heights [5];
      logic [31:0] ext [4];
      heights = '{32'h7fffffff, 32'h80000000, 32'h00010000, 32'hfff38000, 32'h0};
      ext = '{32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff};
      cycle_count = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      req_x_coord = '0;
      req_y_coord = '0;
      req_z_coord = '0;
      req_on_cylinder_patch = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: axis points, zero radius on both patches, extremes
      send_point(0, 0, 0, 1'b1);
      send_point(0, 0, 0, 1'b0);
      send_point(0, 0, 32'h00050000, 1'b0);
      send_point(0, 0, 32'hfffb0000, 1'b0);
      send_point(0, 0, 32'h00050000, 1'b1);
      for (int i = 0; i < 4; i++) begin
         send_point(ext[i], ext[3 - i], ext[(i + 1) % 4], 1'b0);
         send_point(ext[i], 0, ext[i], 1'b1);
         send_point(0, ext[i], 0, 1'b0);
      end
      send_point(32'h00010000, 32'h00010000, 0, 1'b0);
      send_point(32'h00030000, 32'hfffc0000, 32'h00020000, 1'b1);

      for (int phase = 0; phase < 5; phase++) begin
         set_cap_height(phase == 4 ? $urandom : heights[phase]);
         if (phase == 0) begin
            // zero radius at the cap centre
            send_point(0, 0, heights[0], 1'b0);
         end else if (phase == 1) begin
            send_point(0, 0, heights[1], 1'b0);
         end
         for (int k = 0; k < 140; k++) begin
            if (k % 35 == 0) idle_pct = (k / 35 == 0) ? 0 : (k / 35 == 1) ? 62 :
                                        (k / 35 == 2) ? 19 : 0;
            send_point(rand_coord(), rand_coord(),
                       $urandom_range(0, 3) == 0 ? csr_wdata : rand_coord(),
                       1'(($urandom >> 3) & 1));
         end
         idle_pct = 0;
      end

      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
design/csl_pkg.sv
design/cylinder_sphere_local_frame.sv
design/csl_checker.sv
bench/cylinder_sphere_local_frame_checker.sv
bench/cylinder_sphere_local_frame_tb.sv
